[src/assert_macros.svh]
// Assertion helpers shared by the RTL. All checks sample on clk and are
// suspended while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge.
`define OLE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define OLE_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define OLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/ole_pkg.sv]
package ole_pkg;

  // Field widths
  localparam int FUNC_W = 3;
  localparam int VAL_W  = 32;
  localparam int PTR_W  = 7;
  localparam int CNT_W  = 7;
  localparam int ST_W   = 2;

  // Default pool size
  localparam int DEF_CAPACITY = 64;

  // Link code for "no node"
  localparam logic [PTR_W-1:0] NULL_PTR = 7'h7F;

  // Request codes
  localparam logic [FUNC_W-1:0] F_INS_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] F_INS_END   = 3'd1;
  localparam logic [FUNC_W-1:0] F_INS_POS   = 3'd2;
  localparam logic [FUNC_W-1:0] F_DEL_FRONT = 3'd3;
  localparam logic [FUNC_W-1:0] F_DEL_END   = 3'd4;
  localparam logic [FUNC_W-1:0] F_DEL_POS   = 3'd5;
  localparam logic [FUNC_W-1:0] F_DISPLAY   = 3'd6;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_OOB   = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

endpackage

[src/ordered_list_engine.sv]
// Bounded singly linked list kept in a node pool of CAPACITY entries.
// Request channel: func/value/position are taken at a clock edge where start
// is high and busy is low. Busy stays high while the request is being worked.
// Result channel: each result word sits on status/value_res/last/count for one
// cycle with done high; the receiver always takes it. last marks the final
// word of a request. Every request but display gives one word; a display of
// a non-empty list gives one word per element, in list order, on back-to-back
// cycles.
// Sequence, p the position: a rejected request, an unused code or an empty
// display gives its word straight from idle. An insert walks to the node
// before p when p is above 1, reads the free head, writes the new node, then
// the previous link or head. A delete walks the same way, reads the target
// link when p is not 0, updates the previous link or head, then returns the
// node to the free chain. A display streams values from head to tail.
// The walk does one link memory read a cycle through its single read port.
// A new request can be accepted in the cycle its last result is shown.
// Reset empties the list and rebuilds the free chain at once through per-entry
// valid bits on the link memory; no clearing pass is needed.
`include "assert_macros.svh"

module ordered_list_engine
  import ole_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [FUNC_W-1:0]       func,
  input  logic signed [VAL_W-1:0] value,
  input  logic [CNT_W-1:0]        position,
  output logic                    done,
  output logic [ST_W-1:0]         status,
  output logic signed [VAL_W-1:0] value_res,
  output logic                    last,
  output logic [CNT_W-1:0]        count
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [PTR_W-1:0] CAP_P = PTR_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_WALK      = 9'b000000010,
    S_INS_RD_FR = 9'b000000100,
    S_INS_WR_NW = 9'b000001000,
    S_INS_WR_PV = 9'b000010000,
    S_DEL_RD_N  = 9'b000100000,
    S_DEL_WR_PV = 9'b001000000,
    S_DEL_WR_N  = 9'b010000000,
    S_DISP      = 9'b100000000
  } state_t;

  state_t state;

  // Control registers
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] free;
  logic [CNT_W-1:0] elem_count;
  logic [PTR_W-1:0] cur;
  logic [PTR_W-1:0] nnode;
  logic [PTR_W-1:0] nxt;
  logic [CNT_W-1:0] steps;
  logic             op_ins;
  logic             is_front;
  logic [VAL_W-1:0] val_in;

  // Node pool memories
  logic [PTR_W-1:0]    link_mem [CAPACITY];
  logic [VAL_W-1:0]    val_mem  [CAPACITY];
  logic [CAPACITY-1:0] link_vld;

  logic [PTR_W-1:0] rd_ptr;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] addr_q;
  logic [PTR_W-1:0] link_q;
  logic             vld_q;
  logic [VAL_W-1:0] val_q;
  logic [PTR_W-1:0] addr_inc;
  logic [PTR_W-1:0] link_rd;

  logic             link_we;
  logic [PTR_W-1:0] link_wptr;
  logic [PTR_W-1:0] link_wdata;
  logic             val_we;
  logic [IDX_W-1:0] link_widx;
  logic [IDX_W-1:0] val_widx;

  // Request decode
  logic             req_ins;
  logic             req_del;
  logic [CNT_W-1:0] req_pos;
  logic             reject;
  logic [ST_W-1:0]  reject_st;

  assign busy = (state != S_IDLE);

  // Decode the request in the accept cycle
  always_comb begin
    req_ins   = (func == F_INS_FRONT) || (func == F_INS_END) || (func == F_INS_POS);
    req_del   = (func == F_DEL_FRONT) || (func == F_DEL_END) || (func == F_DEL_POS);
    req_pos   = '0;
    reject    = 1'b0;
    reject_st = ST_OK;
    case (func)
      F_INS_END: req_pos = elem_count;
      F_INS_POS: req_pos = position;
      F_DEL_END: req_pos = elem_count - CNT_W'(1);
      F_DEL_POS: req_pos = position;
      default:   req_pos = '0;
    endcase
    if (req_ins) begin
      if (elem_count == CAP_C) begin
        reject    = 1'b1;
        reject_st = ST_FULL;
      end else if (req_pos > elem_count) begin
        reject    = 1'b1;
        reject_st = ST_OOB;
      end
    end else if (req_del) begin
      if (elem_count == '0) begin
        reject    = 1'b1;
        reject_st = ST_EMPTY;
      end else if (req_pos >= elem_count) begin
        reject    = 1'b1;
        reject_st = ST_OOB;
      end
    end else if (func == F_DISPLAY) begin
      if (elem_count == '0) begin
        reject    = 1'b1;
        reject_st = ST_EMPTY;
      end
    end else begin
      reject    = 1'b1;
      reject_st = ST_OK;
    end
  end

  // Select the read address and the write port for each step
  always_comb begin
    rd_ptr     = head;
    link_we    = 1'b0;
    link_wptr  = cur;
    link_wdata = nnode;
    val_we     = 1'b0;
    case (state)
      S_WALK:      rd_ptr = link_rd;
      S_INS_RD_FR: rd_ptr = free;
      S_DEL_RD_N:  rd_ptr = link_rd;
      S_DISP:      rd_ptr = link_rd;
      S_INS_WR_NW: begin
        link_we    = 1'b1;
        link_wptr  = free;
        link_wdata = nxt;
        val_we     = 1'b1;
      end
      S_INS_WR_PV: begin
        link_we    = !is_front;
        link_wptr  = cur;
        link_wdata = nnode;
      end
      S_DEL_WR_PV: begin
        link_we    = !is_front;
        link_wptr  = cur;
        link_wdata = link_rd;
      end
      S_DEL_WR_N: begin
        link_we    = 1'b1;
        link_wptr  = nnode;
        link_wdata = free;
      end
      default: rd_ptr = head;
    endcase
  end

  assign rd_idx    = rd_ptr[IDX_W-1:0];
  assign link_widx = link_wptr[IDX_W-1:0];
  assign val_widx  = free[IDX_W-1:0];

  // Link and value memories: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_widx] <= link_wdata;
    end
    if (val_we) begin
      val_mem[val_widx] <= val_in;
    end
    link_q <= link_mem[rd_idx];
    val_q  <= val_mem[rd_idx];
    addr_q <= rd_idx;
    vld_q  <= link_vld[rd_idx];
  end

  // Mark link entries written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      link_vld <= '0;
    end else if (link_we) begin
      link_vld[link_widx] <= 1'b1;
    end
  end

  // Unwritten link entries read as the initial free chain
  assign addr_inc = PTR_W'(addr_q) + PTR_W'(1);
  assign link_rd  = vld_q ? link_q : ((addr_inc == CAP_P) ? NULL_PTR : addr_inc);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      head       <= NULL_PTR;
      free       <= '0;
      elem_count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            val_in <= value;
            cur    <= head;
            nnode  <= head;
            steps  <= (func == F_DISPLAY) ? elem_count : req_pos - CNT_W'(1);
            op_ins <= req_ins;
            is_front <= (req_pos == '0);
            if (reject) begin
              done      <= 1'b1;
              status    <= reject_st;
              value_res <= '0;
              last      <= 1'b1;
              count     <= elem_count;
            end else if (req_ins) begin
              state <= (req_pos > CNT_W'(1)) ? S_WALK : S_INS_RD_FR;
            end else if (req_del) begin
              if (req_pos == '0) begin
                state <= S_DEL_WR_PV;
              end else if (req_pos == CNT_W'(1)) begin
                state <= S_DEL_RD_N;
              end else begin
                state <= S_WALK;
              end
            end else begin
              state <= S_DISP;
            end
          end
        end
        // Follow one link a cycle until the node before the target
        S_WALK: begin
          cur   <= link_rd;
          steps <= steps - CNT_W'(1);
          if (steps == CNT_W'(1)) begin
            state <= op_ins ? S_INS_RD_FR : S_DEL_RD_N;
          end
        end
        S_INS_RD_FR: begin
          nxt   <= is_front ? head : link_rd;
          state <= S_INS_WR_NW;
        end
        S_INS_WR_NW: begin
          nnode <= free;
          free  <= link_rd;
          state <= S_INS_WR_PV;
        end
        S_INS_WR_PV: begin
          if (is_front) begin
            head <= nnode;
          end
          elem_count <= elem_count + CNT_W'(1);
          done       <= 1'b1;
          status     <= ST_OK;
          value_res  <= '0;
          last       <= 1'b1;
          count      <= elem_count + CNT_W'(1);
          state      <= S_IDLE;
        end
        S_DEL_RD_N: begin
          nnode <= link_rd;
          state <= S_DEL_WR_PV;
        end
        S_DEL_WR_PV: begin
          if (is_front) begin
            head <= link_rd;
          end
          state <= S_DEL_WR_N;
        end
        S_DEL_WR_N: begin
          free       <= nnode;
          elem_count <= elem_count - CNT_W'(1);
          done       <= 1'b1;
          status     <= ST_OK;
          value_res  <= '0;
          last       <= 1'b1;
          count      <= elem_count - CNT_W'(1);
          state      <= S_IDLE;
        end
        // Emit one element a cycle from head to tail
        S_DISP: begin
          done      <= 1'b1;
          status    <= ST_OK;
          value_res <= $signed(val_q);
          last      <= (steps == CNT_W'(1));
          count     <= elem_count;
          steps     <= steps - CNT_W'(1);
          if (steps == CNT_W'(1)) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  `OLE_ASSERT_ALWAYS(a_count_cap, elem_count <= CAP_C, "element count above capacity")
  `OLE_ASSERT_IMPLY(a_head_count, state == S_IDLE, (head == NULL_PTR) == (elem_count == '0), "head and count disagree")
  `OLE_ASSERT_IMPLY(a_free_valid, (state == S_IDLE) && (elem_count < CAP_C), free < CAP_P, "free chain lost")
  `OLE_ASSERT_NEXT(a_disp_burst, done && !last, done && (status == ST_OK), "display burst broken")

endmodule
